FILE: hdl/kt3d_pkg.sv
// kt3d_pkg: formats, limits, codes and saturation helpers for the 3-axis
// constant-velocity tracker
// no dependencies
package kt3d_pkg;

    localparam int COV_FRAC_BITS  = 32;
    localparam int TIME_FRAC_BITS = 20;

    localparam int POS_W   = 32;
    localparam int COV_W   = 48;
    localparam int STAMP_W = 48;
    localparam int NOISE_W = 47;
    localparam int GAP_W   = 32;
    localparam int JUMP_W  = 31;
    localparam int DIFF_W  = POS_W + 1;
    localparam int WIDE_W  = 64;
    localparam int PROD_W  = 2 * WIDE_W;
    localparam int NUM_W   = COV_W + COV_FRAC_BITS;
    localparam int DEN_W   = COV_W + 1;
    localparam int AXES    = 3;

    localparam logic signed [WIDE_W-1:0] LIM_GAIN = 64'sd1 <<< 62;
    localparam logic signed [WIDE_W-1:0] LIM_COV  = 64'sd1 <<< 50;
    localparam logic signed [WIDE_W-1:0] LIM_POS  = 64'sd1 <<< 40;
    localparam logic signed [WIDE_W-1:0] MAX32    = 64'sd2147483647;
    localparam logic signed [WIDE_W-1:0] MIN32    = -64'sd2147483648;
    localparam logic signed [WIDE_W-1:0] MAX48    = 64'sh0000_7fff_ffff_ffff;
    localparam logic signed [WIDE_W-1:0] MIN48    = 64'shffff_8000_0000_0000;

    localparam logic [1:0] FUNC_OBSERVE = 2'd0;
    localparam logic [1:0] FUNC_SET_POS = 2'd1;

    localparam logic [2:0] OUT_FILTERED = 3'd0;
    localparam logic [2:0] OUT_FIRST    = 3'd1;
    localparam logic [2:0] OUT_REVERSE  = 3'd2;
    localparam logic [2:0] OUT_GAP      = 3'd3;
    localparam logic [2:0] OUT_JUMP     = 3'd4;
    localparam logic [2:0] OUT_RESET    = 3'd5;

    localparam logic [2:0] REG_Q_POS   = 3'd0;
    localparam logic [2:0] REG_Q_VEL   = 3'd1;
    localparam logic [2:0] REG_R_POS   = 3'd2;
    localparam logic [2:0] REG_P0_POS  = 3'd3;
    localparam logic [2:0] REG_P0_VEL  = 3'd4;
    localparam logic [2:0] REG_MAX_GAP = 3'd5;
    localparam logic [2:0] REG_JUMP    = 3'd6;

    typedef struct packed {
        logic signed [POS_W-1:0] p;
        logic signed [POS_W-1:0] v;
        logic signed [COV_W-1:0] pp;
        logic signed [COV_W-1:0] pv;
        logic signed [COV_W-1:0] vv;
    } t_axis_state;

    function automatic logic signed [POS_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
        if (x > MAX32) begin
            return MAX32[POS_W-1:0];
        end else if (x < MIN32) begin
            return MIN32[POS_W-1:0];
        end
        return x[POS_W-1:0];
    endfunction

    function automatic logic signed [COV_W-1:0] sat48(input logic signed [WIDE_W-1:0] x);
        if (x > MAX48) begin
            return MAX48[COV_W-1:0];
        end else if (x < MIN48) begin
            return MIN48[COV_W-1:0];
        end
        return x[COV_W-1:0];
    endfunction

    function automatic logic [WIDE_W-1:0] mag64(input logic signed [WIDE_W-1:0] x);
        return (x < 0) ? WIDE_W'(-x) : WIDE_W'(x);
    endfunction

endpackage

FILE: hdl/kalman_tracker_3d_const_velocity.sv
// kalman_tracker_3d_const_velocity: top level of the 3-axis tracker
// sequencer, per-axis state memory, shared multiplier and gain divider
// depends on kt3d_pkg
//
// One word is handled at a time. A full filtered observation runs, per
// axis, a 4-product predict on the shared multiplier, which runs four
// 32x32 passes per product, then four products for the distance test,
// then per axis a bit-serial divider for both gains followed by five
// products. With no elapsed time the predict products are skipped. The
// axis state sits in a 3-entry memory with a registered read; it is read
// only once the track has started, and every start writes all three
// entries, so it needs no clearing after reset. The result word is held
// on the output until taken, and the next word is accepted in the cycle
// it is taken.
module kalman_tracker_3d_const_velocity
    import kt3d_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [1:0]                i_func,
    input  logic signed [POS_W-1:0]   i_obs_x,
    input  logic signed [POS_W-1:0]   i_obs_y,
    input  logic signed [POS_W-1:0]   i_obs_z,
    input  logic [STAMP_W-1:0]        i_stamp,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [POS_W-1:0]   o_est_x,
    output logic signed [POS_W-1:0]   o_est_y,
    output logic signed [POS_W-1:0]   o_est_z,
    output logic signed [POS_W-1:0]   o_vel_x,
    output logic signed [POS_W-1:0]   o_vel_y,
    output logic signed [POS_W-1:0]   o_vel_z,
    output logic                      o_vel_valid,
    output logic [2:0]                o_outcome,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [5:0]                paddr,
    input  logic [63:0]               pwdata,
    output logic [63:0]               prdata,
    output logic                      pready
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CHECK    = 4'd1;
    localparam logic [3:0] S_INIT     = 4'd2;
    localparam logic [3:0] S_RD       = 4'd3;
    localparam logic [3:0] S_LAT      = 4'd4;
    localparam logic [3:0] S_MUL_LOAD = 4'd5;
    localparam logic [3:0] S_MUL_ACC  = 4'd6;
    localparam logic [3:0] S_MUL_RND  = 4'd7;
    localparam logic [3:0] S_MUL_FIN  = 4'd8;
    localparam logic [3:0] S_PRED_WB  = 4'd9;
    localparam logic [3:0] S_LIMCMP   = 4'd10;
    localparam logic [3:0] S_DIV      = 4'd11;
    localparam logic [3:0] S_DIV_FIN  = 4'd12;
    localparam logic [3:0] S_UPD_WB   = 4'd13;

    localparam logic [3:0] OP_T2  = 4'd0;
    localparam logic [3:0] OP_T1  = 4'd1;
    localparam logic [3:0] OP_T3  = 4'd2;
    localparam logic [3:0] OP_DP  = 4'd3;
    localparam logic [3:0] OP_SQ0 = 4'd4;
    localparam logic [3:0] OP_SQ1 = 4'd5;
    localparam logic [3:0] OP_SQ2 = 4'd6;
    localparam logic [3:0] OP_LIM = 4'd7;
    localparam logic [3:0] OP_KPD = 4'd8;
    localparam logic [3:0] OP_KVD = 4'd9;
    localparam logic [3:0] OP_KPP = 4'd10;
    localparam logic [3:0] OP_KPV = 4'd11;
    localparam logic [3:0] OP_KVV = 4'd12;

    localparam logic [1:0] SH_NONE = 2'd0;
    localparam logic [1:0] SH_TIME = 2'd1;
    localparam logic [1:0] SH_COV  = 2'd2;

    localparam logic [1:0] LM_GAIN = 2'd0;
    localparam logic [1:0] LM_COV  = 2'd1;
    localparam logic [1:0] LM_POS  = 2'd2;

    localparam logic PH_PRED = 1'b0;
    localparam logic PH_UPD  = 1'b1;

    localparam logic [1:0] LAST_AXIS = 2'(AXES - 1);
    localparam logic [6:0] DIV_LAST  = 7'(NUM_W - 1);

    // configuration
    logic [NOISE_W-1:0] r_q_pos, r_q_vel, r_r_pos, r_p0_pos, r_p0_vel;
    logic [GAP_W-1:0]   r_max_gap;
    logic [JUMP_W-1:0]  r_jump_lim;

    // control and item registers
    logic [3:0]               r_state;
    logic                     r_out_valid;
    logic                     r_started;
    logic [2:0]               r_outcome;
    logic [STAMP_W-1:0]       r_last;
    logic [STAMP_W-1:0]       r_stamp;
    logic [STAMP_W-1:0]       r_init_stamp;
    logic                     r_init_obs;
    logic signed [POS_W-1:0]  r_obs [AXES];
    logic [GAP_W-1:0]         r_dt;
    logic                     r_dt_nz;
    logic                     r_phase;
    logic [1:0]               r_axis;
    logic                     r_jump;
    logic [3:0]               r_op;
    logic signed [DIFF_W-1:0] r_d [AXES];
    logic signed [WIDE_W-1:0] r_ta, r_tb, r_tc, r_td, r_te;
    logic [WIDE_W-1:0]        r_sum, r_limsq;
    logic signed [WIDE_W-1:0] r_kp, r_kv;
    logic signed [POS_W-1:0]  r_pos [AXES];
    logic signed [POS_W-1:0]  r_vel [AXES];

    // shared multiplier
    logic [WIDE_W-1:0] r_ma, r_mb, r_mr;
    logic              r_mneg, r_mover;
    logic [1:0]        r_msh, r_mlim, r_mcnt;
    logic [PROD_W-1:0] r_acc;

    // gain divider, two numerators over one denominator
    logic [NUM_W-1:0] r_dn0, r_dn1;
    logic [DEN_W-1:0] r_rem0, r_rem1, r_den;
    logic             r_dneg0, r_dneg1;
    logic [6:0]       r_dcnt;

    // axis state memory
    t_axis_state r_mem [AXES];
    t_axis_state r_mem_q;
    logic        mem_we, mem_re;
    logic [1:0]  mem_wa, mem_ra;
    t_axis_state mem_wd;

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb begin
        case (paddr[5:3])
            REG_Q_POS:   prdata = 64'(r_q_pos);
            REG_Q_VEL:   prdata = 64'(r_q_vel);
            REG_R_POS:   prdata = 64'(r_r_pos);
            REG_P0_POS:  prdata = 64'(r_p0_pos);
            REG_P0_VEL:  prdata = 64'(r_p0_vel);
            REG_MAX_GAP: prdata = 64'(r_max_gap);
            REG_JUMP:    prdata = 64'(r_jump_lim);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_pos    <= '0;
            r_q_vel    <= '0;
            r_r_pos    <= NOISE_W'(1);
            r_p0_pos   <= '0;
            r_p0_vel   <= '0;
            r_max_gap  <= '0;
            r_jump_lim <= '0;
        end else if (cfg_wr) begin
            case (paddr[5:3])
                REG_Q_POS:   r_q_pos    <= pwdata[NOISE_W-1:0];
                REG_Q_VEL:   r_q_vel    <= pwdata[NOISE_W-1:0];
                REG_R_POS:   r_r_pos    <= pwdata[NOISE_W-1:0];
                REG_P0_POS:  r_p0_pos   <= pwdata[NOISE_W-1:0];
                REG_P0_VEL:  r_p0_vel   <= pwdata[NOISE_W-1:0];
                REG_MAX_GAP: r_max_gap  <= pwdata[GAP_W-1:0];
                REG_JUMP:    r_jump_lim <= pwdata[JUMP_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // datapath helpers
    // ---------------------------------------------------------------
    logic                     in_acc;
    logic [STAMP_W-1:0]       dt_full;
    t_axis_state              w;
    t_axis_state              n_pred, n_upd, n_init;
    logic signed [WIDE_W-1:0] t2_clamp, pp_sum, cov_den;
    logic signed [DIFF_W-1:0] n_diff;
    logic [DIFF_W-1:0]        diff_mag;
    logic                     jump_now;

    assign in_acc  = i_valid && o_ready;
    assign dt_full = r_stamp - r_last;
    assign w       = r_mem_q;

    always_comb begin
        if (r_ta > LIM_COV) begin
            t2_clamp = LIM_COV;
        end else if (r_ta < -LIM_COV) begin
            t2_clamp = -LIM_COV;
        end else begin
            t2_clamp = r_ta;
        end
        pp_sum = 64'(w.pp) + (r_tb <<< 1) + r_tc + $signed(64'(r_q_pos));
        if (r_dt_nz) begin
            n_pred.p  = sat32(64'(w.p) + r_td);
            n_pred.v  = w.v;
            n_pred.pp = sat48(pp_sum);
            n_pred.pv = sat48(64'(w.pv) + t2_clamp);
            n_pred.vv = sat48(64'(w.vv) + $signed(64'(r_q_vel)));
        end else begin
            n_pred = w;
        end
        n_diff   = DIFF_W'(r_obs[r_axis]) - DIFF_W'(n_pred.p);
        diff_mag = n_diff[DIFF_W-1] ? DIFF_W'(-n_diff) : DIFF_W'(n_diff);
        jump_now = r_jump || (diff_mag > DIFF_W'(r_jump_lim));

        n_upd.p  = sat32(64'(w.p) + r_ta);
        n_upd.v  = sat32(64'(w.v) + r_tb);
        n_upd.pp = sat48(64'(w.pp) - r_tc);
        n_upd.pv = sat48(64'(w.pv) - r_td);
        n_upd.vv = sat48(64'(w.vv) - r_te);

        n_init.p  = r_init_obs ? r_obs[r_axis] : r_pos[r_axis];
        n_init.v  = '0;
        n_init.pp = $signed(COV_W'(r_p0_pos));
        n_init.pv = '0;
        n_init.vv = $signed(COV_W'(r_p0_vel));

        // innovation variance
        cov_den = 64'(w.pp) + $signed(64'(r_r_pos));
    end

    // memory port control
    always_comb begin
        mem_we = 1'b0;
        mem_wd = n_init;
        case (r_state)
            S_INIT: begin
                mem_we = 1'b1;
                mem_wd = n_init;
            end
            S_PRED_WB: begin
                mem_we = 1'b1;
                mem_wd = n_pred;
            end
            S_UPD_WB: begin
                mem_we = 1'b1;
                mem_wd = n_upd;
            end
            default: ;
        endcase
        mem_wa = r_axis;
        mem_re = (r_state == S_RD);
        mem_ra = r_axis;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_mem_q <= r_mem[mem_ra];
        end
    end

    // multiplier operand selection
    logic signed [WIDE_W-1:0] mul_a, mul_b;
    logic [1:0]               mul_sh, mul_lim;

    always_comb begin
        mul_a   = $signed(64'(w.vv));
        mul_b   = $signed(64'(r_dt));
        mul_sh  = SH_TIME;
        mul_lim = LM_GAIN;
        case (r_op)
            OP_T2: begin
                mul_a = 64'(w.vv);
            end
            OP_T1: begin
                mul_a   = 64'(w.pv);
                mul_lim = LM_COV;
            end
            OP_T3: begin
                mul_a   = r_ta;
                mul_lim = LM_COV;
            end
            OP_DP: begin
                mul_a   = 64'(w.v);
                mul_lim = LM_POS;
            end
            OP_SQ0, OP_SQ1, OP_SQ2: begin
                mul_a  = 64'(r_d[r_op[1:0]]);
                mul_b  = 64'(r_d[r_op[1:0]]);
                mul_sh = SH_NONE;
            end
            OP_LIM: begin
                mul_a  = $signed(64'(r_jump_lim));
                mul_b  = $signed(64'(r_jump_lim));
                mul_sh = SH_NONE;
            end
            OP_KPD: begin
                mul_a   = r_kp;
                mul_b   = 64'(r_d[r_axis]);
                mul_sh  = SH_COV;
                mul_lim = LM_POS;
            end
            OP_KVD: begin
                mul_a   = r_kv;
                mul_b   = 64'(r_d[r_axis]);
                mul_sh  = SH_COV;
                mul_lim = LM_POS;
            end
            OP_KPP: begin
                mul_a   = r_kp;
                mul_b   = 64'(w.pp);
                mul_sh  = SH_COV;
                mul_lim = LM_COV;
            end
            OP_KPV: begin
                mul_a   = r_kp;
                mul_b   = 64'(w.pv);
                mul_sh  = SH_COV;
                mul_lim = LM_COV;
            end
            OP_KVV: begin
                mul_a   = r_kv;
                mul_b   = 64'(w.pv);
                mul_sh  = SH_COV;
                mul_lim = LM_COV;
            end
            default: ;
        endcase
    end

    // one 32x32 partial product per pass
    logic [31:0]       part_a, part_b;
    logic [WIDE_W-1:0] part_p;
    logic [PROD_W-1:0] part_sh;

    always_comb begin
        part_a = r_mcnt[1] ? r_ma[63:32] : r_ma[31:0];
        part_b = r_mcnt[0] ? r_mb[63:32] : r_mb[31:0];
        part_p = part_a * part_b;
        case (r_mcnt)
            2'd0:    part_sh = PROD_W'(part_p);
            2'd3:    part_sh = PROD_W'(part_p) << 64;
            default: part_sh = PROD_W'(part_p) << 32;
        endcase
    end

    // round to nearest, ties away from zero, on the magnitude
    logic [PROD_W-1:0] rnd_shifted;

    always_comb begin
        case (r_msh)
            SH_TIME: rnd_shifted = (r_acc + (PROD_W'(1) << (TIME_FRAC_BITS - 1)))
                                   >> TIME_FRAC_BITS;
            SH_COV:  rnd_shifted = (r_acc + (PROD_W'(1) << (COV_FRAC_BITS - 1)))
                                   >> COV_FRAC_BITS;
            default: rnd_shifted = r_acc;
        endcase
    end

    logic [WIDE_W-1:0]        fin_lim, fin_mag;
    logic signed [WIDE_W-1:0] mres;

    always_comb begin
        case (r_mlim)
            LM_COV:  fin_lim = WIDE_W'(LIM_COV);
            LM_POS:  fin_lim = WIDE_W'(LIM_POS);
            default: fin_lim = WIDE_W'(LIM_GAIN);
        endcase
        fin_mag = (r_mover || (r_mr > fin_lim)) ? fin_lim : r_mr;
        mres    = r_mneg ? -$signed(fin_mag) : $signed(fin_mag);
    end

    // restoring division step for both gains
    logic [DEN_W:0]   div_t0, div_t1;
    logic             div_ge0, div_ge1;
    logic [DEN_W-1:0] n_rem0, n_rem1;

    always_comb begin
        div_t0  = {r_rem0, r_dn0[NUM_W-1]};
        div_t1  = {r_rem1, r_dn1[NUM_W-1]};
        div_ge0 = div_t0 >= {1'b0, r_den};
        div_ge1 = div_t1 >= {1'b0, r_den};
        n_rem0  = div_ge0 ? DEN_W'(div_t0 - {1'b0, r_den}) : DEN_W'(div_t0);
        n_rem1  = div_ge1 ? DEN_W'(div_t1 - {1'b0, r_den}) : DEN_W'(div_t1);
    end

    logic [WIDE_W-1:0] gain0, gain1;

    always_comb begin
        gain0 = (r_dn0 > NUM_W'(LIM_GAIN)) ? WIDE_W'(LIM_GAIN) : r_dn0[WIDE_W-1:0];
        gain1 = (r_dn1 > NUM_W'(LIM_GAIN)) ? WIDE_W'(LIM_GAIN) : r_dn1[WIDE_W-1:0];
    end

    logic [WIDE_W-1:0] pp_mag, pv_mag;
    assign pp_mag = mag64(64'(w.pp));
    assign pv_mag = mag64(64'(w.pv));

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    assign o_ready = (r_state == S_IDLE) && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_started   <= 1'b0;
            r_outcome   <= OUT_FILTERED;
            r_last      <= '0;
            r_axis      <= '0;
            r_phase     <= PH_PRED;
            r_jump      <= 1'b0;
            r_op        <= OP_T2;
            r_mcnt      <= '0;
            r_dcnt      <= '0;
            for (int k = 0; k < AXES; k++) begin
                r_pos[k] <= '0;
                r_vel[k] <= '0;
            end
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (mem_we) begin
                r_pos[mem_wa] <= mem_wd.p;
                r_vel[mem_wa] <= mem_wd.v;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_obs[0]     <= i_obs_x;
                        r_obs[1]     <= i_obs_y;
                        r_obs[2]     <= i_obs_z;
                        r_stamp      <= i_stamp;
                        r_axis       <= '0;
                        r_init_stamp <= '0;
                        r_init_obs   <= (i_func == FUNC_SET_POS);
                        if (i_func == FUNC_OBSERVE) begin
                            r_state <= S_CHECK;
                        end else begin
                            r_outcome <= OUT_RESET;
                            r_state   <= S_INIT;
                        end
                    end
                end
                S_CHECK: begin
                    r_init_stamp <= r_stamp;
                    r_init_obs   <= 1'b1;
                    r_dt         <= dt_full[GAP_W-1:0];
                    r_dt_nz      <= (dt_full != '0);
                    if (!r_started) begin
                        r_outcome <= OUT_FIRST;
                        r_state   <= S_INIT;
                    end else if (r_stamp < r_last) begin
                        r_outcome <= OUT_REVERSE;
                        r_state   <= S_INIT;
                    end else if (dt_full > STAMP_W'(r_max_gap)) begin
                        r_outcome <= OUT_GAP;
                        r_state   <= S_INIT;
                    end else begin
                        r_phase <= PH_PRED;
                        r_jump  <= 1'b0;
                        r_state <= S_RD;
                    end
                end
                S_INIT: begin
                    if (r_axis == LAST_AXIS) begin
                        r_last      <= r_init_stamp;
                        r_started   <= 1'b1;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_axis <= r_axis + 2'd1;
                    end
                end
                S_RD: begin
                    r_state <= S_LAT;
                end
                S_LAT: begin
                    if (r_phase == PH_PRED) begin
                        r_op    <= OP_T2;
                        r_state <= r_dt_nz ? S_MUL_LOAD : S_PRED_WB;
                    end else if (cov_den > 0) begin
                        r_den   <= DEN_W'(cov_den);
                        r_dn0   <= {pp_mag[COV_W-1:0], COV_FRAC_BITS'(0)};
                        r_dn1   <= {pv_mag[COV_W-1:0], COV_FRAC_BITS'(0)};
                        r_dneg0 <= w.pp[COV_W-1];
                        r_dneg1 <= w.pv[COV_W-1];
                        r_rem0  <= '0;
                        r_rem1  <= '0;
                        r_dcnt  <= '0;
                        r_state <= S_DIV;
                    end else if (r_axis == LAST_AXIS) begin
                        // no update possible on this axis, keep the prediction
                        r_last      <= r_stamp;
                        r_outcome   <= OUT_FILTERED;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_axis  <= r_axis + 2'd1;
                        r_state <= S_RD;
                    end
                end
                S_MUL_LOAD: begin
                    r_ma    <= mag64(mul_a);
                    r_mb    <= mag64(mul_b);
                    r_mneg  <= (mul_a < 0) != (mul_b < 0);
                    r_msh   <= mul_sh;
                    r_mlim  <= mul_lim;
                    r_acc   <= '0;
                    r_mcnt  <= '0;
                    r_state <= S_MUL_ACC;
                end
                S_MUL_ACC: begin
                    r_acc  <= r_acc + part_sh;
                    r_mcnt <= r_mcnt + 2'd1;
                    if (r_mcnt == 2'd3) begin
                        r_state <= S_MUL_RND;
                    end
                end
                S_MUL_RND: begin
                    r_mr    <= rnd_shifted[WIDE_W-1:0];
                    r_mover <= |rnd_shifted[PROD_W-1:WIDE_W];
                    r_state <= S_MUL_FIN;
                end
                S_MUL_FIN: begin
                    case (r_op)
                        OP_T2, OP_KPD: r_ta <= mres;
                        OP_T1, OP_KVD: r_tb <= mres;
                        OP_T3, OP_KPP: r_tc <= mres;
                        OP_DP, OP_KPV: r_td <= mres;
                        OP_KVV:        r_te <= mres;
                        OP_LIM:        r_limsq <= WIDE_W'(mres);
                        default:       r_sum <= r_sum + WIDE_W'(mres);
                    endcase
                    if (r_op == OP_DP) begin
                        r_state <= S_PRED_WB;
                    end else if (r_op == OP_LIM) begin
                        r_state <= S_LIMCMP;
                    end else if (r_op == OP_KVV) begin
                        r_state <= S_UPD_WB;
                    end else begin
                        r_op    <= r_op + 4'd1;
                        r_state <= S_MUL_LOAD;
                    end
                end
                S_PRED_WB: begin
                    r_d[r_axis] <= n_diff;
                    r_jump      <= jump_now;
                    if (r_axis != LAST_AXIS) begin
                        r_axis  <= r_axis + 2'd1;
                        r_state <= S_RD;
                    end else if (jump_now) begin
                        r_outcome <= OUT_JUMP;
                        r_axis    <= '0;
                        r_state   <= S_INIT;
                    end else begin
                        r_sum   <= '0;
                        r_op    <= OP_SQ0;
                        r_state <= S_MUL_LOAD;
                    end
                end
                S_LIMCMP: begin
                    r_axis <= '0;
                    if (r_sum > r_limsq) begin
                        r_outcome <= OUT_JUMP;
                        r_state   <= S_INIT;
                    end else begin
                        r_phase <= PH_UPD;
                        r_state <= S_RD;
                    end
                end
                S_DIV: begin
                    r_rem0 <= n_rem0;
                    r_rem1 <= n_rem1;
                    r_dn0  <= {r_dn0[NUM_W-2:0], div_ge0};
                    r_dn1  <= {r_dn1[NUM_W-2:0], div_ge1};
                    r_dcnt <= r_dcnt + 7'd1;
                    if (r_dcnt == DIV_LAST) begin
                        r_state <= S_DIV_FIN;
                    end
                end
                S_DIV_FIN: begin
                    r_kp    <= r_dneg0 ? -$signed(gain0) : $signed(gain0);
                    r_kv    <= r_dneg1 ? -$signed(gain1) : $signed(gain1);
                    r_op    <= OP_KPD;
                    r_state <= S_MUL_LOAD;
                end
                S_UPD_WB: begin
                    if (r_axis == LAST_AXIS) begin
                        r_last      <= r_stamp;
                        r_outcome   <= OUT_FILTERED;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_axis  <= r_axis + 2'd1;
                        r_state <= S_RD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid     = r_out_valid;
    assign o_est_x     = r_pos[0];
    assign o_est_y     = r_pos[1];
    assign o_est_z     = r_pos[2];
    assign o_vel_x     = r_vel[0];
    assign o_vel_y     = r_vel[1];
    assign o_vel_z     = r_vel[2];
    assign o_vel_valid = r_started;
    assign o_outcome   = r_outcome;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    // a read never meets a write of the same entry
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && mem_re) |-> (mem_wa != mem_ra))
        else $error("state memory read and write clash");

    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (mem_wa != 2'd3))
        else $error("write beyond the last axis");

    // every result word follows a start of the track
    a_word_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_started)
        else $error("result word without a started track");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != S_IDLE) && !r_out_valid)
        else $error("accepted word not taken into work");

endmodule
